### src/column_depth_occlusion_cull_macros.svh
// ----------------------------------------------------------------------------
// Column depth occlusion cull: assertion macros
// Shared assertion shorthands, clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef COLUMN_DEPTH_OCCLUSION_CULL_MACROS_SVH
`define COLUMN_DEPTH_OCCLUSION_CULL_MACROS_SVH

// Same-cycle implication.
`define CDOC_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cdoc: same-cycle check failed");

// Next-cycle implication.
`define CDOC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cdoc: next-cycle check failed");

`endif

### src/cdoc_pkg.sv
// ----------------------------------------------------------------------------
// Column depth occlusion cull: package
// Field widths, opcodes and the controller/datapath command and status types.
// ----------------------------------------------------------------------------
package cdoc_pkg;

   localparam int COL_W       = 9;   // column field width
   localparam int IZ_W        = 32;  // unsigned Q8.24 inverse depth
   localparam int ACC_W       = 42;  // signed interpolation accumulator
   localparam int VIS_W       = 10;  // visible column count
   localparam int DEF_COLUMNS = 512;

   localparam int REQ_DATA_W  = 88;
   localparam int REQ_USER_W  = 2;
   localparam int RSP_DATA_W  = 16;
   localparam int RSP_USER_W  = 1;

   localparam logic OP_CLEAR = 1'b0;
   localparam logic OP_SPAN  = 1'b1;

   typedef struct packed {
      logic load;      // capture a span item
      logic issue;     // read the current column and advance
      logic clr_start; // restart the clearing sweep
      logic clr_step;  // zero one store entry
      logic out_load;  // move the span count into the result register
   } cdoc_cmd_type;

   typedef struct packed {
      logic span_empty; // span has no on-screen columns
      logic col_last;   // current column is the last one to read
      logic clr_last;   // clearing sweep is at the last entry
   } cdoc_sts_type;

endpackage

### src/cdoc_datapath.sv
// ----------------------------------------------------------------------------
// Column depth occlusion cull: datapath
// Depth store, inverse depth interpolator, depth compare and visible counter.
// ----------------------------------------------------------------------------
module cdoc_datapath
   import cdoc_pkg::*;
#(
   parameter int COLUMNS = DEF_COLUMNS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cdoc_cmd_type            cmd,
   output cdoc_sts_type            sts,
   input  logic [COL_W-1:0]        in_first_column,
   input  logic [COL_W-1:0]        in_last_column,
   input  logic [IZ_W-1:0]         in_iz_start,
   input  logic signed [IZ_W-1:0]  in_iz_step,
   input  logic                    in_opaque,
   output logic [VIS_W-1:0]        out_visible_columns,
   output logic                    out_survives
);

   localparam int IDX_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam int CMP_W = COL_W + IDX_W + 1;
   localparam logic [CMP_W-1:0] LAST_IDX = CMP_W'(COLUMNS - 1);

   logic [IZ_W-1:0] depth_mem [COLUMNS];

   logic [COL_W-1:0]        col_ff, col_in;
   logic [COL_W-1:0]        end_ff, end_in;
   logic                    empty_ff, empty_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [ACC_W-1:0] step_ff, step_in;
   logic                    opaque_ff, opaque_in;
   logic                    b_valid_ff, b_valid_in;
   logic [IDX_W-1:0]        b_addr_ff, b_addr_in;
   logic [IZ_W-1:0]         b_iz_ff, b_iz_in;
   logic [IZ_W-1:0]         rd_ff;
   logic [VIS_W-1:0]        count_ff, count_in;
   logic [IDX_W-1:0]        clr_ff, clr_in;
   logic [VIS_W-1:0]        vis_ff, vis_in;
   logic                    surv_ff, surv_in;

   logic [CMP_W-1:0] last_wide, clip_wide, col_wide;
   logic [IDX_W-1:0] rd_addr, wr_addr;
   logic [IZ_W-1:0]  iz_sat, wr_data;
   logic             hit, wr_en;

   // Clip the span to the store; columns past the store are off screen.
   always_comb begin
      last_wide = CMP_W'(in_last_column);
      clip_wide = (last_wide > LAST_IDX) ? LAST_IDX : last_wide;
      end_in    = clip_wide[COL_W-1:0];
      empty_in  = CMP_W'(in_first_column) > clip_wide;
   end

   assign col_wide = CMP_W'(col_ff);
   assign rd_addr  = col_wide[IDX_W-1:0];

   // Saturate the interpolated value to the unsigned Q8.24 range.
   always_comb begin
      if (acc_ff[ACC_W-1]) begin
         iz_sat = '0;
      end else if (acc_ff[ACC_W-2:IZ_W] != '0) begin
         iz_sat = '1;
      end else begin
         iz_sat = acc_ff[IZ_W-1:0];
      end
   end

   assign hit     = b_valid_ff && (b_iz_ff >= rd_ff);
   assign wr_en   = cmd.clr_step || (hit && opaque_ff);
   assign wr_addr = cmd.clr_step ? clr_ff : b_addr_ff;
   assign wr_data = cmd.clr_step ? '0 : b_iz_ff;

   always_comb begin
      col_in     = col_ff;
      acc_in     = acc_ff;
      step_in    = step_ff;
      opaque_in  = opaque_ff;
      b_valid_in = cmd.issue;
      b_addr_in  = rd_addr;
      b_iz_in    = iz_sat;
      count_in   = count_ff + VIS_W'(hit);
      clr_in     = clr_ff;
      vis_in     = vis_ff;
      surv_in    = surv_ff;
      if (cmd.load) begin
         col_in    = in_first_column;
         acc_in    = ACC_W'(in_iz_start);
         step_in   = ACC_W'(in_iz_step);
         opaque_in = in_opaque;
         count_in  = '0;
      end else if (cmd.issue) begin
         col_in = col_ff + COL_W'(1);
         acc_in = acc_ff + step_ff;
      end
      if (cmd.clr_start) begin
         clr_in = '0;
      end else if (cmd.clr_step) begin
         clr_in = clr_ff + IDX_W'(1);
      end
      if (cmd.out_load) begin
         vis_in  = count_ff;
         surv_in = (count_ff != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         count_ff   <= '0;
         clr_ff     <= '0;
      end else begin
         b_valid_ff <= b_valid_in;
         count_ff   <= count_in;
         clr_ff     <= clr_in;
      end
      col_ff    <= col_in;
      acc_ff    <= acc_in;
      step_ff   <= step_in;
      opaque_ff <= opaque_in;
      b_addr_ff <= b_addr_in;
      b_iz_ff   <= b_iz_in;
      vis_ff    <= vis_in;
      surv_ff   <= surv_in;
      if (cmd.load) begin
         end_ff   <= end_in;
         empty_ff <= empty_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         depth_mem[wr_addr] <= wr_data;
      end
      rd_ff <= depth_mem[rd_addr];
   end

   assign sts.span_empty = empty_ff;
   assign sts.col_last   = (col_ff == end_ff);
   assign sts.clr_last   = (clr_ff == IDX_W'(COLUMNS - 1));

   assign out_visible_columns = vis_ff;
   assign out_survives        = surv_ff;

endmodule

### src/cdoc_ctrl.sv
// ----------------------------------------------------------------------------
// Column depth occlusion cull: controller
// Sequences the clearing sweep, the column walk of a span and the result beat.
// ----------------------------------------------------------------------------
module cdoc_ctrl
   import cdoc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic         req_opcode,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output cdoc_cmd_type cmd,
   input  cdoc_sts_type sts
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SPAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_opcode == OP_CLEAR) begin
                  cmd.clr_start = 1'b1;
                  state_in      = ST_CLEAR;
               end else begin
                  cmd.load = 1'b1;
                  state_in = ST_SPAN;
               end
            end
         end
         ST_SPAN: begin
            if (sts.span_empty) begin
               state_in = ST_FINISH;
            end else begin
               cmd.issue = 1'b1;
               if (sts.col_last) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            // The last column is compared and counted in this cycle.
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### src/column_depth_occlusion_cull.sv
// ----------------------------------------------------------------------------
// Column depth occlusion cull: top level
// One-dimensional inverse depth buffer that tests spans front to back.
//
//   Channel  Dir  Handshake            Payload
//   req      in   req_tvalid/tready    tdata: columns, iz start, iz step
//                                      tuser: opcode, opaque
//   rsp      out  rsp_tvalid/tready    tdata: visible_columns; tuser: survives
//
// A span item walks one column per cycle through the depth store (one read
// and one write a cycle); the finish state then waits for a free result register.
// A clear item sweeps the store one entry per cycle.
// After reset the same sweep runs before the first beat is accepted.
// A waiting result beat does not block the next item; only the end of the
// following span waits for the result register to drain.
// ----------------------------------------------------------------------------
`include "column_depth_occlusion_cull_macros.svh"

module column_depth_occlusion_cull
   import cdoc_pkg::*;
#(
   parameter int COLUMNS = DEF_COLUMNS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // first_column[8:0], last_column[17:9], iz_start[49:18], iz_step[81:50], zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // opcode[0], opaque[1]
   input  logic [REQ_USER_W-1:0] req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // visible_columns[9:0], zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // survives[0]
   output logic [RSP_USER_W-1:0] rsp_tuser
);

   cdoc_cmd_type     cmd;
   cdoc_sts_type     sts;
   logic [VIS_W-1:0] visible_columns;
   logic             survives;

   cdoc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_opcode (req_tuser[0]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   cdoc_datapath #(
      .COLUMNS (COLUMNS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .in_first_column     (req_tdata[COL_W-1:0]),
      .in_last_column      (req_tdata[2*COL_W-1:COL_W]),
      .in_iz_start         (req_tdata[2*COL_W+IZ_W-1:2*COL_W]),
      .in_iz_step          (req_tdata[2*COL_W+2*IZ_W-1:2*COL_W+IZ_W]),
      .in_opaque           (req_tuser[1]),
      .out_visible_columns (visible_columns),
      .out_survives        (survives)
   );

   assign rsp_tdata = RSP_DATA_W'(visible_columns);
   assign rsp_tuser = RSP_USER_W'(survives);

   // The survive flag must agree with the count it travels with.
   `CDOC_ASSERT_NOW(a_survive_matches_count, rsp_tvalid, survives == (visible_columns != '0))
   // Off-screen columns are never counted.
   `CDOC_ASSERT_NOW(a_count_within_store, rsp_tvalid, 32'(visible_columns) <= 32'(COLUMNS))
   // Every accepted item keeps the block busy for at least the next cycle.
   `CDOC_ASSERT_NEXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready)

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// Column depth occlusion cull: testbench
// Sends clear and span beats into the block, predicts each span's visible
// column count and survive flag from its own copy of the depth store, and
// compares every result beat with the oldest prediction. Both sides idle at
// random in bursts, except in the final phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench
   import cdoc_pkg::*;
();

   typedef struct packed {
      logic [VIS_W-1:0] visible_columns;
      logic             survives;
   } span_verdict_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [REQ_USER_W-1:0] req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;

   logic [IZ_W-1:0]  inv_depth_model [DEF_COLUMNS];
   span_verdict_type verdicts_due [$];
   int               mismatch_count;
   int               items_sent;
   bit               sender_gaps;
   bit               receiver_stalls;

   column_depth_occlusion_cull u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Interpolates each column exactly, saturates to the Q8.24 range, and
   // runs the depth test against the store copy.
   function automatic span_verdict_type predict_span(
      logic [COL_W-1:0] first_col, logic [COL_W-1:0] last_col,
      logic [IZ_W-1:0] iz_start, logic signed [IZ_W-1:0] iz_step, logic opaque);
      span_verdict_type verdict;
      longint           iz_exact;
      logic [IZ_W-1:0]  iz;
      int               count;
      int               k;
      count = 0;
      if (first_col <= last_col) begin
         for (int x = int'(first_col); x <= int'(last_col); x++) begin
            k = x - int'(first_col);
            iz_exact = longint'(iz_start) + longint'(iz_step) * longint'(k);
            if (iz_exact < 0) begin
               iz = '0;
            end else if (iz_exact > 64'sh0_FFFF_FFFF) begin
               iz = '1;
            end else begin
               iz = iz_exact[IZ_W-1:0];
            end
            if (x < DEF_COLUMNS && iz >= inv_depth_model[x]) begin
               count++;
               if (opaque) inv_depth_model[x] = iz;
            end
         end
      end
      verdict.visible_columns = count[VIS_W-1:0];
      verdict.survives        = (count != 0);
      return verdict;
   endfunction

   task automatic send_item(logic opcode, logic [COL_W-1:0] first_col,
      logic [COL_W-1:0] last_col, logic [IZ_W-1:0] iz_start,
      logic [IZ_W-1:0] iz_step, logic opaque);
      if (sender_gaps && $urandom_range(0, 3) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {6'b0, iz_step, iz_start, last_col, first_col};
      req_tuser  = {opaque, opcode};
      do @(posedge clock); while (!req_tready);
      if (opcode == OP_SPAN) begin
         verdicts_due.insert(verdicts_due.size(),
                             predict_span(first_col, last_col, iz_start, iz_step, opaque));
      end else begin
         foreach (inv_depth_model[i]) inv_depth_model[i] = '0;
      end
      items_sent++;
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic wait_for_results();
      while (verdicts_due.size() != 0) @(posedge clock);
   endtask

   // A nearer-to-farther run of spans after a clear, as a renderer sends them.
   task automatic send_frame(int spans);
      logic [IZ_W-1:0]  frame_iz;
      logic [IZ_W-1:0]  iz_step;
      int               width;
      int               first_col;
      frame_iz = $urandom_range(32'hFFFF_FFFF, 32'h4000_0000);
      send_item(OP_CLEAR, COL_W'($urandom), COL_W'($urandom), $urandom, $urandom,
                1'($urandom));
      repeat (spans) begin
         width = ($urandom_range(0, 39) == 0) ? $urandom_range(1, DEF_COLUMNS)
                                              : $urandom_range(1, 64);
         first_col = $urandom_range(0, DEF_COLUMNS - width);
         if ($urandom_range(0, 4) == 0) begin
            iz_step = $urandom;
         end else begin
            iz_step = $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
         end
         frame_iz = frame_iz - (frame_iz >> 4) - $urandom_range(0, 255);
         if ($urandom_range(0, 15) == 0) begin
            // A reversed span now and then, with the ends swapped.
            send_item(OP_SPAN, COL_W'(first_col + width - 1), COL_W'(first_col),
                      frame_iz, iz_step, 1'($urandom));
         end else begin
            send_item(OP_SPAN, COL_W'(first_col), COL_W'(first_col + width - 1),
                      frame_iz ^ $urandom_range(0, 16'hFFFF), iz_step,
                      $urandom_range(0, 3) != 0);
         end
      end
   endtask

   task automatic test_fresh_store();
      send_item(OP_SPAN, 9'd0, 9'd511, 32'h0000_0000, 32'h0000_0000, 1'b1);
      send_item(OP_SPAN, 9'd0, 9'd511, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
   endtask

   task automatic test_saturation();
      send_item(OP_SPAN, 9'd0, 9'd511, 32'h0000_0000, 32'h7FFF_FFFF, 1'b0);
      send_item(OP_SPAN, 9'd0, 9'd511, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1);
      send_item(OP_CLEAR, 9'd511, 9'd511, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      send_item(OP_SPAN, 9'd0, 9'd511, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
      send_item(OP_SPAN, 9'd10, 9'd40, 32'h0000_0005, 32'hFFFF_FFFD, 1'b1);
   endtask

   task automatic test_special_spans();
      send_item(OP_SPAN, 9'd511, 9'd0, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
      send_item(OP_SPAN, 9'd1, 9'd0, 32'hFFFF_FFFF, 32'h0100_0000, 1'b1);
      send_item(OP_SPAN, 9'd511, 9'd511, 32'h0100_0000, 32'h7FFF_FFFF, 1'b1);
      send_item(OP_SPAN, 9'd0, 9'd0, 32'h0000_0001, 32'h8000_0000, 1'b0);
      // The store must be empty again after a clear.
      send_item(OP_CLEAR, 9'd0, 9'd0, 32'h0, 32'h0, 1'b0);
      send_item(OP_SPAN, 9'd0, 9'd511, 32'h0000_0000, 32'h0000_0000, 1'b0);
   endtask

   task automatic test_depth_ties();
      send_item(OP_SPAN, 9'd100, 9'd100, 32'h1234_5678, 32'h0, 1'b1);
      send_item(OP_SPAN, 9'd100, 9'd100, 32'h1234_5678, 32'h0, 1'b0);
      send_item(OP_SPAN, 9'd100, 9'd100, 32'h1234_5677, 32'h0, 1'b1);
      // A see-through span is visible but leaves the store alone.
      send_item(OP_SPAN, 9'd200, 9'd203, 32'hF000_0000, 32'h0, 1'b0);
      send_item(OP_SPAN, 9'd200, 9'd203, 32'h0000_0001, 32'h0, 1'b1);
      send_item(OP_SPAN, 9'd200, 9'd203, 32'h0000_0000, 32'h0, 1'b1);
   endtask

   task automatic test_drain_pause();
      send_frame(8);
      wait_for_results();
      send_frame(8);
   endtask

   task automatic test_random_frames();
      while (items_sent < 560) send_frame($urandom_range(10, 30));
   endtask

   task automatic test_random_noise();
      repeat (100) begin
         send_item(($urandom_range(0, 19) == 0) ? OP_CLEAR : OP_SPAN, COL_W'($urandom),
                   COL_W'($urandom), $urandom, $urandom, 1'($urandom));
      end
   endtask

   task automatic test_back_to_back();
      sender_gaps     = 1'b0;
      receiver_stalls = 1'b0;
      send_frame(40);
      send_item(OP_CLEAR, COL_W'($urandom), COL_W'($urandom), $urandom, $urandom,
                1'($urandom));
   endtask

   // Receiver side: ready drops in random bursts while stalls are enabled.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (receiver_stalls && $urandom_range(0, 5) == 0) begin
            rsp_tready = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clock);
         end
         rsp_tready = !reset;
      end
   end

   always @(posedge clock) begin
      span_verdict_type expected;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (verdicts_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("%0t: result beat with nothing expected: visible %0d survives %0d",
                        $realtime, rsp_tdata[VIS_W-1:0], rsp_tuser[0]);
            end
         end else begin
            expected = verdicts_due.pop_front();
            if (rsp_tdata[VIS_W-1:0] !== expected.visible_columns ||
                rsp_tuser[0] !== expected.survives) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("%0t: visible expected %0d got %0d, survives expected %0d got %0d",
                           $realtime, expected.visible_columns, rsp_tdata[VIS_W-1:0],
                           expected.survives, rsp_tuser[0]);
               end
            end
         end
      end
   end

   initial begin
      #60_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      reset           = 1'b1;
      req_tvalid      = 1'b0;
      req_tdata       = '0;
      req_tuser       = '0;
      mismatch_count  = 0;
      items_sent      = 0;
      sender_gaps     = 1'b1;
      receiver_stalls = 1'b1;
      foreach (inv_depth_model[i]) inv_depth_model[i] = '0;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      test_fresh_store();
      test_saturation();
      test_special_spans();
      test_depth_ties();
      test_drain_pause();
      test_random_frames();
      test_random_noise();
      test_back_to_back();

      wait_for_results();
      // A trailing clear sweeps the whole store; give it time, and catch strays.
      repeat (DEF_COLUMNS + 64) @(posedge clock);
      if (mismatch_count == 0 && verdicts_due.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

### column_depth_occlusion_cull.f
+incdir+src
src/cdoc_pkg.sv
src/cdoc_datapath.sv
src/cdoc_ctrl.sv
src/column_depth_occlusion_cull.sv
sim/testbench.sv
